>>> sv/adh_pkg.sv
// adh_pkg: widths, register indexes and scaling constants for the averaged dimmer
// no dependencies; imported by every adh_* module and the core top level
package adh_pkg;

  // field widths
  localparam int SampleW = 12;
  localparam int AvgW    = 12;
  localparam int DutyW   = 8;
  localparam int LevelW  = 8;
  localparam int SumW    = 16;

  // largest converter value, also the ceiling of the average
  localparam int FullScale = 4095;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegOffLevel = 2'd0;
  localparam cfg_idx_t RegOnLevel  = 2'd1;

  localparam logic [LevelW-1:0] OffLevelReset = 8'd20;
  localparam logic [LevelW-1:0] OnLevelReset  = 8'd30;

  // avg*255/4095 == avg*17/273; exact reciprocal of 273 for 17-bit numerators
  // (shift 17 + 9), with the factor 17 folded into the multiplier
  localparam int ScaleShift = 26;
  localparam int ScaleMulW  = 22;
  localparam int ScaleMul   = ((2**ScaleShift + 272) / 273) * 17;

  // shift for the window reciprocal: sum width plus enough bits for a window up to 16
  localparam int DivShift = SumW + 5;
  localparam int DivMulW  = DivShift + 1;

endpackage

>>> sv/adh_ring.sv
// adh_ring: sample ring, running sum and first pipeline register
// depends on adh_pkg
module adh_ring import adh_pkg::*; #(
  parameter int WINDOW = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SampleW-1:0] in_sample,
  output logic               sum_valid,
  input  logic               sum_ready,
  output logic [SumW-1:0]    sum_value
);

  localparam int PosW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [SampleW-1:0] ring_r [WINDOW];
  logic [PosW-1:0]    pos_r, pos_nxt;
  logic [SumW-1:0]    sum_r, sum_nxt;
  logic               valid_r, valid_nxt;
  logic [SumW-1:0]    out_sum_r;
  logic               accept;

  // stage is free when empty or when the next stage takes its item
  assign in_ready  = !valid_r || sum_ready;
  assign accept    = in_valid && in_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // drop the oldest sample, add the new one
  assign sum_nxt = sum_r - SumW'(ring_r[pos_r]) + SumW'(in_sample);

  // position wraps at the window length
  assign pos_nxt = (pos_r == PosW'(WINDOW - 1)) ? '0 : pos_r + PosW'(1);

  // ring entries, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= '0;
      end
    end else if (accept) begin
      ring_r[pos_r] <= in_sample;
    end
  end

  // control state and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

  // sum handed to the divide stage
  always_ff @(posedge clk) begin
    if (accept) begin
      out_sum_r <= sum_nxt;
    end
  end

  assign sum_valid = valid_r;
  assign sum_value = out_sum_r;

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < WINDOW)
    else $error("ring position beyond window");

  a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sum_r) <= WINDOW * FullScale)
    else $error("running sum exceeds window full scale");

endmodule

>>> sv/adh_divide.sv
// adh_divide: running sum divided by the window length, second pipeline register
// depends on adh_pkg
module adh_divide import adh_pkg::*; #(
  parameter int WINDOW = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            sum_valid,
  output logic            sum_ready,
  input  logic [SumW-1:0] sum_value,
  output logic            avg_valid,
  input  logic            avg_ready,
  output logic [AvgW-1:0] avg_value
);

  // exact reciprocal, rounded up
  localparam int DivMul = (2**DivShift + WINDOW - 1) / WINDOW;
  localparam int ProdW  = SumW + DivMulW;
  localparam int QuotW  = ProdW - DivShift;

  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot;
  logic [AvgW-1:0]  avg_nxt;
  logic [AvgW-1:0]  avg_r;
  logic             valid_r;

  assign sum_ready = !valid_r || avg_ready;

  // multiply by reciprocal and shift
  assign prod = ProdW'(sum_value) * ProdW'(DivMul);
  assign quot = prod[ProdW-1:DivShift];

  // clamp to converter full scale
  assign avg_nxt = (quot > QuotW'(FullScale)) ? AvgW'(FullScale) : quot[AvgW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sum_ready) begin
      valid_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && sum_valid) begin
      avg_r <= avg_nxt;
    end
  end

  assign avg_valid = valid_r;
  assign avg_value = avg_r;

endmodule

>>> sv/adh_gate.sv
// adh_gate: scaling to 0..255, hysteresis gate and result register
// depends on adh_pkg
module adh_gate import adh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              avg_valid,
  output logic              avg_ready,
  input  logic [AvgW-1:0]   avg_value,
  input  logic [LevelW-1:0] off_level,
  input  logic [LevelW-1:0] on_level,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [AvgW-1:0]   out_average,
  output logic [DutyW-1:0]  out_duty,
  output logic              out_lit
);

  localparam int ProdW = AvgW + ScaleMulW;

  logic [ProdW-1:0] prod;
  logic [DutyW-1:0] scaled;
  logic             lit_r, lit_nxt;
  logic [DutyW-1:0] duty_nxt;
  logic             valid_r;
  logic [AvgW-1:0]  average_r;
  logic [DutyW-1:0] duty_r;
  logic             load;

  assign avg_ready = !valid_r || out_ready;
  assign load      = avg_valid && avg_ready;

  // avg * 255 / 4095, truncated
  assign prod   = ProdW'(avg_value) * ProdW'(ScaleMul);
  assign scaled = prod[ProdW-1:ScaleShift];

  // hysteresis on the scaled value
  always_comb begin
    lit_nxt  = lit_r;
    duty_nxt = '0;
    if (lit_r) begin
      if (scaled < off_level) begin
        lit_nxt = 1'b0;
      end else begin
        duty_nxt = scaled;
      end
    end else if (scaled >= on_level) begin
      lit_nxt  = 1'b1;
      duty_nxt = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lit_r   <= 1'b0;
    end else begin
      if (avg_ready) begin
        valid_r <= avg_valid;
      end
      if (load) begin
        lit_r <= lit_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      average_r <= avg_value;
      duty_r    <= duty_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_average = average_r;
  assign out_duty    = duty_r;
  assign out_lit     = lit_r;

  a_dark_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !lit_r |-> duty_r == '0)
    else $error("duty nonzero while output dark");

  a_lit_moves_with_item: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(load) |-> $stable(lit_r))
    else $error("lit flag changed without a new item");

endmodule

>>> sv/averaged_dimmer_with_hysteresis_core.sv
// averaged_dimmer_with_hysteresis_core: top level, configuration registers and pipeline
// depends on adh_pkg, adh_ring, adh_divide, adh_gate
//
// Takes one 12-bit knob reading per item and returns one result per item: the
// truncated mean of the last WINDOW readings, that mean scaled to 0..255, gated
// by an on/off hysteresis flag, and the flag itself. The block accepts one item
// per clock while the output is not stalled. Each result passes three register
// stages, and the first one loads at the edge at which its item is accepted:
// one stage for the ring and running sum, one for the divide by WINDOW
// (a reciprocal multiply), and the result register after scaling and the gate.
// Each stage holds its item only while the next one is full and stalled, so
// input is still taken while a result waits, until every stage is full. The ring
// lives in flip-flops and is cleared by reset, so the average ramps up from zero.
// off_level and on_level may be written at any time the pipeline holds no item.
module averaged_dimmer_with_hysteresis_core import adh_pkg::*; #(
  parameter int WINDOW = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SampleW-1:0]  in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [AvgW-1:0]     out_average,
  output logic [DutyW-1:0]    out_duty,
  output logic                out_lit,
  input  logic                cfg_we,
  input  cfg_idx_t            cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic [LevelW-1:0] off_level_r;
  logic [LevelW-1:0] on_level_r;
  logic              sum_valid, sum_ready;
  logic [SumW-1:0]   sum_value;
  logic              avg_valid, avg_ready;
  logic [AvgW-1:0]   avg_value;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_level_r <= OffLevelReset;
      on_level_r  <= OnLevelReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegOffLevel: off_level_r <= cfg_wdata[LevelW-1:0];
        RegOnLevel:  on_level_r  <= cfg_wdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  adh_ring #(.WINDOW(WINDOW)) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_value (sum_value)
  );

  adh_divide #(.WINDOW(WINDOW)) u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_value (sum_value),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .avg_value (avg_value)
  );

  adh_gate u_gate (
    .clk         (clk),
    .rst_n       (rst_n),
    .avg_valid   (avg_valid),
    .avg_ready   (avg_ready),
    .avg_value   (avg_value),
    .off_level   (off_level_r),
    .on_level    (on_level_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_average (out_average),
    .out_duty    (out_duty),
    .out_lit     (out_lit)
  );

endmodule
